### src/sorted_key_table_top_assert.svh
// assertion macros for the sorted key table
`ifndef SORTED_KEY_TABLE_TOP_ASSERT_SVH
`define SORTED_KEY_TABLE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define SKT_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("sorted key table check failed");
`define SKT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sorted key table check failed");
`define SKT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sorted key table check failed");
`else
`define SKT_ASSERT(lbl, cond)
`define SKT_ASSERT_IMPL(lbl, ante, cons)
`define SKT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### src/skt_pkg.sv
`timescale 1ns / 1ps
package skt_pkg;

    localparam int DEPTH   = 16;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int KEY_W   = 32;
    localparam int IDX_W   = 4;
    localparam int COUNT_W = 5;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_SORT   = 2'd1,
        OP_SEARCH = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DUP  = 2'd1,
        ST_FULL = 2'd2,
        ST_MISS = 2'd3
    } t_status;

    typedef struct packed {
        t_op              opcode;
        logic [KEY_W-1:0] key;
    } t_skt_req;

    typedef struct packed {
        t_status            status;
        logic               found;
        logic [IDX_W-1:0]   index;
        logic [COUNT_W-1:0] entry_count;
    } t_skt_rsp;

    function automatic logic [IDX_W-1:0] to_index(input logic [ADDR_W-1:0] a);
        logic [ADDR_W+IDX_W-1:0] w;
        w = {{IDX_W{1'b0}}, a};
        return w[IDX_W-1:0];
    endfunction

    function automatic logic [COUNT_W-1:0] to_count(input logic [CNT_W-1:0] c);
        logic [CNT_W+COUNT_W-1:0] w;
        w = {{COUNT_W{1'b0}}, c};
        return w[COUNT_W-1:0];
    endfunction

endpackage

### src/sorted_key_table_top.sv
`timescale 1ns / 1ps
// sorted key table: up to 16 unsigned 32-bit keys held in one synchronous RAM
// request channel: start with i_req (opcode, key); taken at a clock edge where
// start is high and busy is low. one request is worked on at a time.
// result channel: o_valid is high for exactly one cycle with o_rsp (status,
// found, index, entry_count); the receiver cannot stall it, so it must take
// every result in the cycle it is shown.
// how each request is worked, n = keys held:
//   clear, sort with n < 2, insert into a full table: answered from idle
//   insert: compares the held keys in order from index 0, stops on a duplicate
//   at index k, else writes the key at index n; search: binary search, ending on
//   a hit at probe p or a miss after p probes, p at most log2(n) + 1
//   sort: passes of compares over the held keys, one compare fewer each pass
// every key access goes through the single RAM read port; a sort pass carries
// the larger key in a register and writes one entry per compare.
// busy stays high until the result is issued; a new request can be taken in
// the cycle the result is shown.
// reset (synchronous, active low) empties the table; RAM contents are left
// as they are and are never used before being written.
module sorted_key_table_top
    import skt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_skt_req i_req,
    output logic     busy,
    output logic     o_valid,
    output t_skt_rsp o_rsp
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SORT_LD,
        S_SORT_FIRST,
        S_SORT_STEP,
        S_SORT_END
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_count;
    logic [ADDR_W-1:0]  r_ptr;
    logic [ADDR_W-1:0]  r_lim;
    logic [ADDR_W-1:0]  r_mid;
    logic [CNT_W-1:0]   r_lo;
    logic [CNT_W-1:0]   r_hi;
    logic [KEY_W-1:0]   r_key;
    logic [KEY_W-1:0]   r_hold;
    logic               r_valid;
    t_skt_rsp           r_rsp;

    logic [KEY_W-1:0]   r_key_mem [DEPTH];
    logic [KEY_W-1:0]   r_rd_data;

    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [KEY_W-1:0]   wr_data;
    logic [CNT_W-1:0]   mid_wide;
    logic [ADDR_W-1:0]  mid;
    logic               accept;
    logic               ins_at_end;
    logic               hold_gt;

    assign accept     = start && !busy;
    assign busy       = (r_state != S_IDLE);
    assign o_valid    = r_valid;
    assign o_rsp      = r_rsp;
    assign ins_at_end = (CNT_W'(r_ptr) == r_count);
    assign hold_gt    = (r_hold > r_rd_data);

    // lo + (hi - lo - 1) / 2 with hi kept exclusive
    assign mid_wide = r_lo + ((r_hi - r_lo - CNT_W'(1)) >> 1);
    assign mid      = mid_wide[ADDR_W-1:0];

    always_comb begin
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = r_ptr;
        wr_data = r_key;
        unique case (r_state)
            S_INS_RD: begin
                rd_addr = r_ptr;
                wr_en   = ins_at_end;
            end
            S_SRCH_RD:    rd_addr = mid;
            S_SORT_FIRST: rd_addr = ADDR_W'(1);
            S_SORT_STEP: begin
                rd_addr = r_ptr + ADDR_W'(2);
                wr_en   = 1'b1;
                wr_data = hold_gt ? r_rd_data : r_hold;
            end
            S_SORT_END: begin
                wr_en   = 1'b1;
                wr_data = r_hold;
            end
            default: rd_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_key_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_key_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_key <= i_req.key;
                        r_ptr <= '0;
                        unique case (i_req.opcode)
                            OP_INSERT: begin
                                if (r_count == CNT_W'(DEPTH)) begin
                                    r_rsp   <= '{status: ST_FULL, found: 1'b0, index: '0,
                                                 entry_count: to_count(r_count)};
                                    r_valid <= 1'b1;
                                end else begin
                                    r_rsp   <= '{status: ST_OK, found: 1'b0, index: '0,
                                                 entry_count: to_count(r_count)};
                                    r_state <= S_INS_RD;
                                end
                            end
                            OP_SORT: begin
                                r_rsp <= '{status: ST_OK, found: 1'b0, index: '0,
                                           entry_count: to_count(r_count)};
                                if (r_count < CNT_W'(2)) begin
                                    r_valid <= 1'b1;
                                end else begin
                                    r_lim   <= ADDR_W'(r_count - CNT_W'(1));
                                    r_state <= S_SORT_LD;
                                end
                            end
                            OP_SEARCH: begin
                                r_rsp   <= '{status: ST_OK, found: 1'b0, index: '0,
                                             entry_count: to_count(r_count)};
                                r_lo    <= '0;
                                r_hi    <= r_count;
                                r_state <= S_SRCH_RD;
                            end
                            OP_CLEAR: begin
                                r_count <= '0;
                                r_rsp   <= '{status: ST_OK, found: 1'b0, index: '0,
                                             entry_count: '0};
                                r_valid <= 1'b1;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_INS_RD: begin
                    if (ins_at_end) begin
                        r_count <= r_count + CNT_W'(1);
                        r_rsp   <= '{status: ST_OK, found: 1'b1, index: to_index(r_ptr),
                                     entry_count: to_count(r_count + CNT_W'(1))};
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_INS_CMP;
                    end
                end
                S_INS_CMP: begin
                    if (r_rd_data == r_key) begin
                        r_rsp.status <= ST_DUP;
                        r_valid      <= 1'b1;
                        r_state      <= S_IDLE;
                    end else begin
                        r_ptr   <= r_ptr + ADDR_W'(1);
                        r_state <= S_INS_RD;
                    end
                end
                S_SRCH_RD: begin
                    if (r_lo >= r_hi) begin
                        r_rsp.status <= ST_MISS;
                        r_valid      <= 1'b1;
                        r_state      <= S_IDLE;
                    end else begin
                        r_mid   <= mid;
                        r_state <= S_SRCH_CMP;
                    end
                end
                S_SRCH_CMP: begin
                    if (r_rd_data == r_key) begin
                        r_rsp.found <= 1'b1;
                        r_rsp.index <= to_index(r_mid);
                        r_valid     <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        if (r_rd_data < r_key) begin
                            r_lo <= CNT_W'(r_mid) + CNT_W'(1);
                        end else begin
                            r_hi <= CNT_W'(r_mid);
                        end
                        r_state <= S_SRCH_RD;
                    end
                end
                S_SORT_LD: begin
                    r_ptr   <= '0;
                    r_state <= S_SORT_FIRST;
                end
                S_SORT_FIRST: begin
                    r_hold  <= r_rd_data;
                    r_state <= S_SORT_STEP;
                end
                S_SORT_STEP: begin
                    // smaller key goes back at r_ptr, larger one rides along
                    if (!hold_gt) begin
                        r_hold <= r_rd_data;
                    end
                    r_ptr <= r_ptr + ADDR_W'(1);
                    if ((r_ptr + ADDR_W'(1)) == r_lim) begin
                        r_state <= S_SORT_END;
                    end
                end
                S_SORT_END: begin
                    r_lim <= r_lim - ADDR_W'(1);
                    if (r_lim == ADDR_W'(1)) begin
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_SORT_LD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`include "sorted_key_table_top_assert.svh"

    `SKT_ASSERT(a_count_range, r_count <= CNT_W'(DEPTH))
    `SKT_ASSERT_IMPL(a_result_when_idle, r_valid, r_state == S_IDLE)
    `SKT_ASSERT_NEXT(a_request_answered, accept, busy || r_valid)
    `SKT_ASSERT_IMPL(a_found_is_ok, r_valid && r_rsp.found, r_rsp.status == ST_OK)
    `SKT_ASSERT_IMPL(a_sort_write_in_range, wr_en && r_state != S_INS_RD,
                     CNT_W'(wr_addr) < r_count)

endmodule
